// ===== hdl/assert_macros.svh =====
// Assertion macros for the display link writer.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define SSDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SSDW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ssdw_pkg.sv =====
// Shared types, codes and constants of the seven-segment display link writer.
// No dependencies.
package ssdw_pkg;

  typedef enum logic [1:0] {
    CmdDigit   = 2'd0,
    CmdSegs    = 2'd1,
    CmdCtrl    = 2'd2,
    CmdRefresh = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SymStart = 2'd0,
    SymBit   = 2'd1,
    SymAck   = 2'd2,
    SymStop  = 2'd3
  } sym_kind_t;

  typedef enum logic [1:0] {
    RegBrightness = 2'd0,
    RegDisplayOn  = 2'd1,
    RegShowColon  = 2'd2
  } reg_index_t;

  localparam logic [7:0] ByteDataFixed = 8'h44;
  localparam logic [7:0] ByteAddrBase  = 8'hC0;
  localparam logic [7:0] ByteCtrlBase  = 8'h80;
  localparam logic [7:0] ColonBit      = 8'h80;
  localparam logic [7:0] BlankDigit    = 8'hFF;
  localparam logic [2:0] ColonPosition = 3'd1;

  // Symbol step numbers of a full write; a control item starts at StepCtrl.
  localparam logic [5:0] StepCtrl = 6'd31;
  localparam logic [5:0] StepLast = 6'd41;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] segs;
    logic [7:0] ctrl;
    logic       ctrl_only;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] seg_code(input logic [7:0] digit);
    logic [7:0] code;
    unique case (digit)
      8'd0: code = 8'h3F;
      8'd1: code = 8'h06;
      8'd2: code = 8'h5B;
      8'd3: code = 8'h4F;
      8'd4: code = 8'h66;
      8'd5: code = 8'h6D;
      8'd6: code = 8'h7D;
      8'd7: code = 8'h07;
      8'd8: code = 8'h7F;
      8'd9: code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/ssdw_front.sv =====
// Front end: config registers, stored digit, and command to frame-byte decode.
// Depends on ssdw_pkg.
module ssdw_front import ssdw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] cmd,
  input  logic [2:0] position,
  input  logic [7:0] payload,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data,
  output desc_t      desc
);

  logic [2:0] brightness;
  logic       display_enabled;
  logic       show_colon;
  logic [7:0] stored_digit;

  logic [2:0] pos;
  logic [7:0] digit;
  logic [7:0] segs;
  logic       is_digit;

  always_comb begin
    is_digit = 1'b0;
    pos      = position;
    digit    = payload;
    unique case (cmd_t'(cmd))
      CmdDigit:   is_digit = 1'b1;
      CmdSegs:    is_digit = 1'b0;
      CmdCtrl:    is_digit = 1'b0;
      CmdRefresh: begin
        is_digit = 1'b1;
        pos      = ColonPosition;
        digit    = stored_digit;
      end
      default:    is_digit = 1'b0;
    endcase
    segs = payload;
    if (is_digit) begin
      segs = seg_code(digit);
      if (pos == ColonPosition && show_colon) segs = segs | ColonBit;
    end
    desc.addr      = ByteAddrBase | {5'd0, pos};
    desc.segs      = segs;
    desc.ctrl      = ByteCtrlBase | {4'd0, display_enabled, brightness};
    desc.ctrl_only = (cmd_t'(cmd) == CmdCtrl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness      <= 3'd7;
      display_enabled <= 1'b1;
      show_colon      <= 1'b0;
      stored_digit    <= BlankDigit;
    end else begin
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          RegBrightness: brightness      <= cfg_data;
          RegDisplayOn:  display_enabled <= cfg_data[0];
          RegShowColon:  show_colon      <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept && is_digit && pos == ColonPosition) stored_digit <= digit;
    end
  end

endmodule

// ===== hdl/ssdw_queue.sv =====
// Two-entry queue of decoded commands between front and back.
// Depends on ssdw_pkg.
module ssdw_queue import ssdw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  desc_t     push_desc,
  input  logic      pop,
  output desc_t     head,
  output q_status_t status
);

  desc_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/ssdw_back.sv =====
// Back end: symbol sequencer stepping one wire symbol a cycle into an output register; out_ready low stalls it.
// Depends on ssdw_pkg.
module ssdw_back import ssdw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  desc_t     head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [1:0] out_kind,
  output logic      out_bit,
  output logic      out_last
);

  logic       busy;
  logic [5:0] step;
  desc_t      cur;

  logic       advance;
  logic       finishing;
  sym_kind_t  kind;
  logic       bit_val;
  logic [5:0] rel;

  assign advance   = busy && (!out_valid || out_ready);
  assign finishing = advance && (step == StepLast);
  assign pop       = !q_status.empty && (!busy || finishing);

  always_comb begin
    kind    = SymStart;
    bit_val = 1'b0;
    rel     = 6'd0;
    priority if (step == 6'd0 || step == 6'd11 || step == StepCtrl) begin
      kind = SymStart;
    end else if (step <= 6'd8) begin
      kind    = SymBit;
      rel     = step - 6'd1;
      bit_val = ByteDataFixed[rel[2:0]];
    end else if (step == 6'd9 || step == 6'd20 || step == 6'd29 || step == 6'd40) begin
      kind = SymAck;
    end else if (step == 6'd10 || step == 6'd30 || step == StepLast) begin
      kind = SymStop;
    end else if (step <= 6'd19) begin
      kind    = SymBit;
      rel     = step - 6'd12;
      bit_val = cur.addr[rel[2:0]];
    end else if (step <= 6'd28) begin
      kind    = SymBit;
      rel     = step - 6'd21;
      bit_val = cur.segs[rel[2:0]];
    end else begin
      kind    = SymBit;
      rel     = step - 6'd32;
      bit_val = cur.ctrl[rel[2:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (advance) begin
      out_kind <= kind;
      out_bit  <= bit_val;
      out_last <= (step == StepLast);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (pop) begin
        busy <= 1'b1;
        step <= head.ctrl_only ? StepCtrl : 6'd0;
      end else if (finishing) begin
        busy <= 1'b0;
      end else if (advance) begin
        step <= step + 6'd1;
      end
    end
  end

endmodule

// ===== hdl/seven_segment_serial_display_writer_top.sv =====
// Top level of the seven-segment display link writer: front, queue, back.
// Depends on ssdw_pkg, ssdw_front, ssdw_queue, ssdw_back and assert_macros.svh.
//
//  channel | direction | handshake          | contents
//  s_*     | in        | s_tvalid/s_tready  | tuser cmd, tdata position+payload
//  m_*     | out       | m_tvalid/m_tready  | tuser symbol_kind, tdata bit_value, tlast
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// A write item yields 42 symbols and a control item 11, one symbol per cycle
// from the back-end step counter while m_tready does not stall the output.
// The front takes an item per cycle while the two-entry queue has room.
// rst is synchronous; it restores the register defaults and a blank stored digit.
// m_tready low holds the output register; the queue keeps s_tready up until full.
`include "assert_macros.svh"
module seven_segment_serial_display_writer_top import ssdw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [2:0] position, [10:3] payload, [15:11] zero
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] bit_value, [7:1] zero
  output logic [1:0]  m_tuser,   // [1:0] symbol_kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  desc_t     front_desc;
  desc_t     head;
  q_status_t q_status;
  logic      s_accept;
  logic      pop;
  logic      out_bit;

  assign s_tready  = !q_status.full;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'd0, out_bit};

  ssdw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .cmd       (s_tuser),
    .position  (s_tdata[2:0]),
    .payload   (s_tdata[10:3]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .desc      (front_desc)
  );

  ssdw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_accept),
    .push_desc (front_desc),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  ssdw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_bit   (out_bit),
    .out_last  (m_tlast)
  );

  `SSDW_ASSERT(a_last_is_stop, m_tvalid && m_tlast |-> m_tuser == SymStop, "last not stop")
  `SSDW_ASSERT(a_level_only_on_bits, m_tvalid && m_tuser != SymBit |-> !out_bit, "bad level")
  `SSDW_ASSERT(a_pop_nonempty, pop |-> !q_status.empty, "pop from empty queue")
  `SSDW_ASSERT_ALWAYS(a_full_blocks_input, q_status.full |-> !s_tready, "input while full")

endmodule
